// File: src/smbct_pkg.sv
// ----------------------------------------------------------------------------
// smbct_pkg
// Shared types, sizes and helpers for the streaming mode-by-count block.
// ----------------------------------------------------------------------------
package smbct_pkg;

    // Data set and count sizing
    localparam int VALUE_COUNT  = 1024;
    localparam int COUNT_BITS   = 16;
    localparam int ADDR_W       = $clog2(VALUE_COUNT);
    localparam int VALUE_W      = 10;
    localparam int MODE_COUNT_W = 16;

    // Set tag kept with every count entry; a mismatching tag reads as zero
    localparam int EPOCH_W = 8;
    localparam int ENTRY_W = EPOCH_W + COUNT_BITS;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [EPOCH_W-1:0]    epoch_t;
    typedef logic [VALUE_W-1:0]    value_t;

    typedef struct packed {
        epoch_t epoch;
        count_t count;
    } entry_t;

    typedef struct packed {
        value_t value;
        logic   last;
    } in_item_t;

    typedef struct packed {
        value_t                  mode_value;
        logic [MODE_COUNT_W-1:0] mode_count;
    } out_item_t;

    // Set tag and sweep status handed from the tag control to the datapath
    typedef struct packed {
        epoch_t epoch;
        logic   clearing;
        addr_t  clr_addr;
    } epoch_ctl_t;

    function automatic addr_t value_index(value_t v);
        return ADDR_W'(v);
    endfunction

    function automatic logic value_in_range(value_t v);
        return (32'(v) < 32'(VALUE_COUNT));
    endfunction

endpackage

// File: src/stream_mode_by_count_table_core.sv
// ----------------------------------------------------------------------------
// stream_mode_by_count_table_core
// Streaming mode finder: per-value counts in one RAM, read-modify-write per
// transfer with a one-deep forward for back-to-back hits on the same value.
// Throughput: one input transfer per cycle, set by the single RAM write port, while no
// sweep runs, no tag wrap is pending and no finished result waits to be taken.
// Reset: counts are swept over all 1024 entries (input not ready); the same sweep
// follows every 256th data set when the set tag wraps.
// ----------------------------------------------------------------------------
module stream_mode_by_count_table_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  smbct_pkg::in_item_t  s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output smbct_pkg::out_item_t m_item
);

    smbct_pkg::epoch_ctl_t ctl;

    logic                  s1_valid_reg;
    smbct_pkg::in_item_t   s1_item_reg;
    logic                  fwd_hit_reg;
    smbct_pkg::entry_t     fwd_entry_reg;
    logic                  m_valid_reg;
    smbct_pkg::out_item_t  m_item_reg;

    logic [smbct_pkg::ENTRY_W-1:0] rd_data;
    logic [smbct_pkg::ENTRY_W-1:0] ram_wdata;
    smbct_pkg::entry_t     raw_entry;
    smbct_pkg::entry_t     wr_entry;
    smbct_pkg::out_item_t  result;
    smbct_pkg::addr_t      s1_idx;
    smbct_pkg::addr_t      ram_waddr;
    logic                  s1_in_range;
    logic                  out_free;
    logic                  s1_fire;
    logic                  s_fire;
    logic                  wrap_pending;
    logic                  item_we;
    logic                  ram_we;
    logic                  set_done;

    // Handshake and write-port steering
    always_comb begin
        s1_idx       = smbct_pkg::value_index(s1_item_reg.value);
        s1_in_range  = smbct_pkg::value_in_range(s1_item_reg.value);
        out_free     = !m_valid_reg || m_ready;
        s1_fire      = s1_valid_reg && (!s1_item_reg.last || out_free);
        wrap_pending = s1_valid_reg && s1_item_reg.last && (&ctl.epoch);
        s_ready      = !ctl.clearing && !wrap_pending && (!s1_valid_reg || s1_fire);
        s_fire       = s_valid && s_ready;
        item_we      = s1_fire && s1_in_range;
        set_done     = s1_fire && s1_item_reg.last;
        ram_we       = item_we || ctl.clearing;
        ram_waddr    = ctl.clearing ? ctl.clr_addr : s1_idx;
        ram_wdata    = ctl.clearing ? '0 : wr_entry;
        raw_entry    = fwd_hit_reg ? fwd_entry_reg : smbct_pkg::entry_t'(rd_data);
    end

    smbct_count_ram #(
        .DEPTH (smbct_pkg::VALUE_COUNT),
        .WIDTH (smbct_pkg::ENTRY_W)
    ) u_count_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (s_fire),
        .rd_addr (smbct_pkg::value_index(s_item.value)),
        .rd_data (rd_data)
    );

    smbct_epoch_ctrl u_epoch_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .set_done (set_done),
        .ctl      (ctl)
    );

    smbct_update u_update (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .value     (s1_item_reg.value),
        .in_range  (s1_in_range),
        .fire      (s1_fire),
        .last      (s1_item_reg.last),
        .raw_entry (raw_entry),
        .epoch     (ctl.epoch),
        .wr_entry  (wr_entry),
        .result    (result)
    );

    // Advance the update stage; forward a write that races the RAM read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else if (s_fire) begin
            s1_valid_reg  <= 1'b1;
            s1_item_reg   <= s_item;
            fwd_hit_reg   <= item_we && (s1_idx == smbct_pkg::value_index(s_item.value));
            fwd_entry_reg <= wr_entry;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Output register: load on a last transfer, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (set_done) begin
            m_valid_reg <= 1'b1;
            m_item_reg  <= result;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// File: src/smbct_count_ram.sv
// ----------------------------------------------------------------------------
// smbct_count_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module smbct_count_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 24
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/smbct_epoch_ctrl.sv
// ----------------------------------------------------------------------------
// smbct_epoch_ctrl
// Set tag counter and clearing sweep over the count memory.
// ----------------------------------------------------------------------------
module smbct_epoch_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  set_done,
    output smbct_pkg::epoch_ctl_t ctl
);

    smbct_pkg::epoch_t epoch_reg;
    logic              clearing_reg;
    smbct_pkg::addr_t  clr_addr_reg;

    // Advance the tag per finished set; sweep after reset and on tag wrap
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_reg    <= '0;
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == smbct_pkg::ADDR_W'(smbct_pkg::VALUE_COUNT - 1)) begin
                clearing_reg <= 1'b0;
                clr_addr_reg <= '0;
            end
        end else if (set_done) begin
            epoch_reg <= epoch_reg + 1'b1;
            if (&epoch_reg) begin
                clearing_reg <= 1'b1;
            end
        end
    end

    assign ctl.epoch    = epoch_reg;
    assign ctl.clearing = clearing_reg;
    assign ctl.clr_addr = clr_addr_reg;

endmodule

// File: src/smbct_update.sv
// ----------------------------------------------------------------------------
// smbct_update
// Count increment with saturation and running best value tracking.
// ----------------------------------------------------------------------------
module smbct_update (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  smbct_pkg::value_t     value,
    input  logic                  in_range,
    input  logic                  fire,
    input  logic                  last,
    input  smbct_pkg::entry_t     raw_entry,
    input  smbct_pkg::epoch_t     epoch,
    output smbct_pkg::entry_t     wr_entry,
    output smbct_pkg::out_item_t  result
);

    smbct_pkg::count_t best_count_reg;
    smbct_pkg::value_t best_value_reg;
    smbct_pkg::count_t best_count_next;
    smbct_pkg::value_t best_value_next;
    smbct_pkg::count_t cur_count;
    smbct_pkg::count_t inc_count;

    // Entries from an older set read as zero; saturate at the top
    always_comb begin
        cur_count = (raw_entry.epoch == epoch) ? raw_entry.count : '0;
        inc_count = (&cur_count) ? cur_count : cur_count + 1'b1;
    end

    assign wr_entry.epoch = epoch;
    assign wr_entry.count = inc_count;

    // Take a new best only on a strictly larger count
    always_comb begin
        best_count_next = best_count_reg;
        best_value_next = best_value_reg;
        if (in_range && (inc_count > best_count_reg)) begin
            best_count_next = inc_count;
            best_value_next = value;
        end
    end

    assign result.mode_value = best_value_next;
    assign result.mode_count = smbct_pkg::MODE_COUNT_W'(best_count_next);

    // Hold best across the set, drop it after the last transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_count_reg <= '0;
            best_value_reg <= '0;
        end else if (fire) begin
            if (last) begin
                best_count_reg <= '0;
                best_value_reg <= '0;
            end else begin
                best_count_reg <= best_count_next;
                best_value_reg <= best_value_next;
            end
        end
    end

endmodule

// File: bench/smbct_mode_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// smbct_mode_checker
// Watches both channels of the mode finder, keeps its own per-value tally of
// every data set, predicts the mode on each last transfer and compares it
// with each result transfer in order.
// ----------------------------------------------------------------------------
module smbct_mode_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  smbct_pkg::in_item_t  s_item,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  smbct_pkg::out_item_t m_item,
    output int                   fail_count,
    output int                   pending
);

    smbct_pkg::count_t    tally [smbct_pkg::VALUE_COUNT];
    smbct_pkg::count_t    lead_count;
    smbct_pkg::value_t    lead_value;
    smbct_pkg::out_item_t mode_expected [$];

    // Clear every count and the running best for a new data set
    function void clear_tally();
        foreach (tally[i]) tally[i] = '0;
        lead_count = '0;
        lead_value = '0;
    endfunction

    initial begin
        fail_count = 0;
        pending    = 0;
        clear_tally();
    end

    always @(posedge aclk) begin : watch
        smbct_pkg::out_item_t want;
        smbct_pkg::count_t    c;
        if (!aresetn) begin
            clear_tally();
            mode_expected.delete();
            fail_count = 0;
        end else begin
            // Check a result transfer against the oldest predicted mode
            if (m_valid && m_ready) begin
                if (mode_expected.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got value %0d count %0d",
                             $time, m_item.mode_value, m_item.mode_count);
                    fail_count++;
                end else begin
                    want = mode_expected.pop_front();
                    if (m_item.mode_value !== want.mode_value) begin
                        $display("%0t: mode_value mismatch: expected %0d, got %0d",
                                 $time, want.mode_value, m_item.mode_value);
                        fail_count++;
                    end
                    if (m_item.mode_count !== want.mode_count) begin
                        $display("%0t: mode_count mismatch: expected %0d, got %0d",
                                 $time, want.mode_count, m_item.mode_count);
                        fail_count++;
                    end
                end
            end

            // Count an input transfer; a strict increase over the best takes over
            if (s_valid && s_ready) begin
                if (32'(s_item.value) < 32'(smbct_pkg::VALUE_COUNT)) begin
                    c = tally[s_item.value];
                    if (c != '1)
                        c = c + 1'b1;
                    tally[s_item.value] = c;
                    if (c > lead_count) begin
                        lead_count = c;
                        lead_value = s_item.value;
                    end
                end
                if (s_item.last) begin
                    want.mode_value = lead_value;
                    want.mode_count = smbct_pkg::MODE_COUNT_W'(lead_count);
                    mode_expected.push_back(want);
                    clear_tally();
                end
            end
        end
        pending = mode_expected.size();
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the streaming mode finder: directed sets for ties,
// repeats and field extremes, then many short random sets (enough to wrap
// the set tag) under bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;

    // Cycles without any transfer before the run is declared hung; covers the
    // count sweep after reset and at each set tag wrap plus the longest stalls
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 1750;
    localparam int SETTLE_CYCLES  = 10;

    // Receiver stall patterns
    localparam int RX_OPEN   = 0;
    localparam int RX_CHOPPY = 1;
    localparam int RX_SLOW   = 2;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    smbct_pkg::in_item_t  s_item;
    logic                 m_valid;
    logic                 m_ready;
    smbct_pkg::out_item_t m_item;

    int fail_count;
    int pending;
    int burst_left;
    int quiet_cycles;
    int items_sent;

    stream_mode_by_count_table_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    smbct_mode_checker i_mode_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Send one value; open a new burst, with a random gap first, when the
    // current one is used up. Return once the transfer has happened.
    task automatic push_value(input smbct_pkg::value_t v, input logic fin);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid      = 1'b1;
        s_item.value = v;
        s_item.last  = fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // One random data set: mostly short, drawn from a small pool of values
    // so that repeats and ties are common, sometimes from the full range
    task automatic send_random_set(output int len);
        int                r;
        int                pool_n;
        bit                wide;
        smbct_pkg::value_t pool [8];
        smbct_pkg::value_t v;
        r = $urandom_range(0, 99);
        if (r < 60)
            len = $urandom_range(1, 3);
        else if (r < 90)
            len = $urandom_range(4, 10);
        else
            len = $urandom_range(11, 40);
        wide   = ($urandom_range(0, 9) >= 7);
        pool_n = $urandom_range(1, 8);
        foreach (pool[k])
            pool[k] = $urandom_range(0, 1) ? smbct_pkg::value_t'($urandom_range(0, 15))
                                           : smbct_pkg::value_t'($urandom_range(0, 1023));
        v = '0;
        for (int i = 0; i < len; i++) begin
            if (i == 0 || $urandom_range(0, 3) != 0)
                v = wide ? smbct_pkg::value_t'($urandom_range(0, 1023))
                         : pool[$urandom_range(0, pool_n - 1)];
            push_value(v, i == len - 1);
        end
    endtask

    // Receiver: hold each stall pattern for a random stretch
    initial begin : receiver
        int rx_mode;
        int rx_left;
        rx_mode = RX_OPEN;
        rx_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_left == 0) begin
                rx_mode = $urandom_range(RX_OPEN, RX_SLOW);
                rx_left = $urandom_range(16, 96);
            end
            rx_left--;
            case (rx_mode)
                RX_OPEN:   m_ready = 1'b1;
                RX_CHOPPY: m_ready = 1'($urandom_range(0, 1));
                default:   m_ready = ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int len;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_item       = '0;
        burst_left   = 0;
        quiet_cycles = 0;
        items_sent   = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Single-item sets at both value extremes
        push_value(10'd0, 1'b1);
        push_value(10'd1023, 1'b1);
        // Tie: the later value reaches two first and keeps the mode
        push_value(10'd5, 1'b0);
        push_value(10'd7, 1'b0);
        push_value(10'd7, 1'b0);
        push_value(10'd5, 1'b1);
        // Tie: the earlier value reaches two first
        push_value(10'd3, 1'b0);
        push_value(10'd9, 1'b0);
        push_value(10'd3, 1'b0);
        push_value(10'd9, 1'b1);
        // Back-to-back hits on one value
        push_value(10'd1023, 1'b0);
        push_value(10'd1023, 1'b0);
        push_value(10'd1023, 1'b0);
        push_value(10'd0, 1'b1);
        // Alternating bit patterns
        push_value(10'b1010101010, 1'b0);
        push_value(10'b0101010101, 1'b1);

        // Random sets, enough of them to wrap the set tag
        while (items_sent < RANDOM_ITEMS) begin
            send_random_set(len);
            items_sent += len;
        end
        @(negedge aclk);
        s_valid = 1'b0;

        // Drain the results, then allow for the result latency
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
